// ===== rtl/core/spq_pkg.sv =====
// Package for the stable priority queue: operation and error codes,
// and the structs passed along the row of queue cells.
// No dependencies.
package spq_pkg;

  // Widths of an entry handle, the operation code, the error code and the entry count.
  localparam int unsigned ID_W   = 4;
  localparam int unsigned FUNC_W = 2;
  localparam int unsigned ERR_W  = 2;
  localparam int unsigned CNT_W  = 5;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

  // Error codes.
  localparam logic [ERR_W-1:0] ERR_NONE   = 2'd0;
  localparam logic [ERR_W-1:0] ERR_FULL   = 2'd1;
  localparam logic [ERR_W-1:0] ERR_ABSENT = 2'd2;

  // Control broadcast to every cell for the current word.
  typedef struct packed {
    logic            rem;   // take the named entry out if it is queued
    logic            ins;   // place the named entry after the take-out
    logic [ID_W-1:0] id;    // handle named by the operation
  } cell_ctl_t;

  // Link passed from a cell to its right-hand neighbor.
  typedef struct packed {
    logic            found;     // named entry sits at or left of this cell
    logic            r_used;    // slot occupied after the take-out
    logic            le;        // slot key after the take-out is not above the new key
    logic [ID_W-1:0] r_handle;  // slot handle after the take-out
  } link_t;

endpackage

// ===== rtl/core/spq_if.sv =====
// Handshake channels of the stable priority queue: operation words in,
// result words out. Depends on spq_pkg.
interface spq_in_if import spq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [ID_W-1:0]   entry_id;
  logic [31:0]       score;

  modport source (output valid, func, entry_id, score, input ready);
  modport sink   (input valid, func, entry_id, score, output ready);
endinterface

interface spq_out_if import spq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             lowest_valid;
  logic [ID_W-1:0]  lowest_id;
  logic             next_valid;
  logic [ID_W-1:0]  next_id;
  logic             was_queued;
  logic [CNT_W-1:0] entry_count;
  logic [ERR_W-1:0] op_error;

  modport source (output valid, lowest_valid, lowest_id, next_valid, next_id,
                  was_queued, entry_count, op_error, input ready);
  modport sink   (input valid, lowest_valid, lowest_id, next_valid, next_id,
                  was_queued, entry_count, op_error, output ready);
endinterface

// ===== rtl/core/stable_priority_queue.sv =====
// Top level of the stable priority queue: a row of spq_cell slots, the
// entry count and the result register. Depends on spq_pkg, spq_if, spq_cell.

// The queue keeps up to QUEUE_DEPTH entry handles in ascending key order, ties
// in arrival order, in a row of slots that each compare against the incoming
// key in parallel and shift one place in the same cycle. Every operation word
// (add or re-add, remove, query successor) updates the row of slots at once and
// one result word is registered at the output; a new word is taken in every
// cycle as long as the result register is empty or being drained. The longest
// path is the ripple of the found flag along the row of slots, plus one key
// compare in each slot.
module stable_priority_queue import spq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned KEY_BITS    = 32
) (
  input  logic     clk,
  input  logic     rst,
  spq_in_if.sink   in_word,
  spq_out_if.source out_word
);

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic                accept;
  logic                out_valid;
  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  logic [KEY_BITS-1:0] op_key;
  cell_ctl_t           ctl;
  logic                queued;
  logic                full;
  logic                drop;
  logic [ERR_W-1:0]    err;
  logic                succ_v_any;
  logic [ID_W-1:0]     succ_id_any;

  link_t               link     [QUEUE_DEPTH+1];
  logic [KEY_BITS-1:0] link_key [QUEUE_DEPTH+1];
  logic                cur_used   [QUEUE_DEPTH+1];
  logic [ID_W-1:0]     cur_handle [QUEUE_DEPTH+1];
  logic [KEY_BITS-1:0] cur_key    [QUEUE_DEPTH+1];
  logic                nxt_used   [QUEUE_DEPTH];
  logic [ID_W-1:0]     nxt_handle [QUEUE_DEPTH];
  logic                succ_valid [QUEUE_DEPTH];
  logic [ID_W-1:0]     succ_id    [QUEUE_DEPTH];

  assign in_word.ready = !out_valid || out_word.ready;
  assign accept        = in_word.valid && in_word.ready;
  assign out_word.valid = out_valid;

  // Decode the operation into the controls shared by all slots.
  assign op_key  = KEY_BITS'(in_word.score);
  assign queued  = link[QUEUE_DEPTH].found;
  assign full    = (count == CW'(QUEUE_DEPTH));
  assign drop    = (in_word.func == FUNC_ADD) && !queued && full;
  assign ctl.rem = (in_word.func == FUNC_ADD) || (in_word.func == FUNC_REMOVE);
  assign ctl.ins = (in_word.func == FUNC_ADD) && !drop;
  assign ctl.id  = in_word.entry_id;

  // Boundary links: nothing sits left of the first slot or right of the last.
  assign link[0].found    = 1'b0;
  assign link[0].r_used   = 1'b0;
  assign link[0].le       = 1'b1;
  assign link[0].r_handle = '0;
  assign link_key[0]      = '0;
  assign cur_used[QUEUE_DEPTH]   = 1'b0;
  assign cur_handle[QUEUE_DEPTH] = '0;
  assign cur_key[QUEUE_DEPTH]    = '0;

  // The row of slots.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    spq_cell #(
      .KEY_BITS (KEY_BITS)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .en           (accept),
      .ctl          (ctl),
      .op_key       (op_key),
      .lin          (link[i]),
      .lin_key      (link_key[i]),
      .right_used   (cur_used[i+1]),
      .right_handle (cur_handle[i+1]),
      .right_key    (cur_key[i+1]),
      .lout         (link[i+1]),
      .lout_key     (link_key[i+1]),
      .cur_used     (cur_used[i]),
      .cur_handle   (cur_handle[i]),
      .cur_key      (cur_key[i]),
      .nxt_used     (nxt_used[i]),
      .nxt_handle   (nxt_handle[i]),
      .succ_valid   (succ_valid[i]),
      .succ_id      (succ_id[i])
    );
  end

  // Collect the successor; at most one slot matches the named handle.
  always_comb begin
    succ_v_any  = 1'b0;
    succ_id_any = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      succ_v_any  = succ_v_any | succ_valid[i];
      succ_id_any = succ_id_any | succ_id[i];
    end
  end

  // Entry count and error code.
  always_comb begin
    count_next = count;
    err        = ERR_NONE;
    case (in_word.func)
      FUNC_ADD: begin
        if (drop) begin
          err = ERR_FULL;
        end else if (!queued) begin
          count_next = count + CW'(1);
        end
      end
      FUNC_REMOVE: begin
        if (queued) begin
          count_next = count - CW'(1);
        end else begin
          err = ERR_ABSENT;
        end
      end
      FUNC_QUERY: begin
        if (!queued) begin
          err = ERR_ABSENT;
        end
      end
      default: begin
        err = ERR_NONE;
      end
    endcase
  end

  // Control state: entry count and result-register occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count <= count_next;
      end
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_word.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result word, loaded with the state after the operation.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_word.lowest_valid <= nxt_used[0];
      out_word.lowest_id    <= nxt_used[0] ? nxt_handle[0] : '0;
      out_word.next_valid   <= (in_word.func == FUNC_QUERY) && succ_v_any;
      out_word.next_id      <= (in_word.func == FUNC_QUERY) ? succ_id_any : '0;
      out_word.was_queued   <= queued;
      out_word.entry_count  <= CNT_W'(count_next);
      out_word.op_error     <= err;
    end
  end

endmodule

// ===== rtl/core/spq_cell.sv =====
// One slot of the sorted queue. It holds a handle and a key and moves them
// one place left or right together with its neighbors. Depends on spq_pkg.
module spq_cell import spq_pkg::*; #(
  parameter int unsigned KEY_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  cell_ctl_t           ctl,
  input  logic [KEY_BITS-1:0] op_key,
  input  link_t               lin,
  input  logic [KEY_BITS-1:0] lin_key,
  input  logic                right_used,
  input  logic [ID_W-1:0]     right_handle,
  input  logic [KEY_BITS-1:0] right_key,
  output link_t               lout,
  output logic [KEY_BITS-1:0] lout_key,
  output logic                cur_used,
  output logic [ID_W-1:0]     cur_handle,
  output logic [KEY_BITS-1:0] cur_key,
  output logic                nxt_used,
  output logic [ID_W-1:0]     nxt_handle,
  output logic                succ_valid,
  output logic [ID_W-1:0]     succ_id
);

  logic                used;
  logic [ID_W-1:0]     handle;
  logic [KEY_BITS-1:0] key;
  logic                match;
  logic                shift;
  logic                r_used;
  logic [ID_W-1:0]     r_handle;
  logic [KEY_BITS-1:0] r_key;
  logic                le;
  logic [KEY_BITS-1:0] nxt_key;

  assign match = used && (handle == ctl.id);

  // Take-out view: every slot from the named entry on pulls from the right.
  assign shift    = ctl.rem && (lin.found || match);
  assign r_used   = shift ? right_used   : used;
  assign r_handle = shift ? right_handle : handle;
  assign r_key    = shift ? right_key    : key;
  assign le       = r_used && (r_key <= op_key);

  assign lout.found    = lin.found || match;
  assign lout.r_used   = r_used;
  assign lout.le       = le;
  assign lout.r_handle = r_handle;
  assign lout_key      = r_key;

  // Insertion: stay if not above the new key, take the new entry at the
  // boundary, otherwise take the left neighbor's slot.
  always_comb begin
    if (ctl.ins) begin
      if (le) begin
        nxt_used   = r_used;
        nxt_handle = r_handle;
        nxt_key    = r_key;
      end else if (lin.le) begin
        nxt_used   = 1'b1;
        nxt_handle = ctl.id;
        nxt_key    = op_key;
      end else begin
        nxt_used   = lin.r_used;
        nxt_handle = lin.r_handle;
        nxt_key    = lin_key;
      end
    end else begin
      nxt_used   = r_used;
      nxt_handle = r_handle;
      nxt_key    = r_key;
    end
  end

  // Successor of the named entry, as seen before the update.
  assign succ_valid = match && right_used;
  assign succ_id    = succ_valid ? right_handle : '0;

  assign cur_used   = used;
  assign cur_handle = handle;
  assign cur_key    = key;

  // Occupancy is control state and is cleared on reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else if (en) begin
      used <= nxt_used;
    end
  end

  // Slot contents need no reset; only occupied slots are ever read.
  always_ff @(posedge clk) begin
    if (en) begin
      handle <= nxt_handle;
      key    <= nxt_key;
    end
  end

endmodule

// ===== test/stable_priority_queue_tb.sv =====
// Self-checking testbench for stable_priority_queue: directed table, then random
// operation words under several idle and stall mixes, checked against a sorted-order model.
// Depends on spq_pkg, spq_if and the stable_priority_queue RTL.
module stable_priority_queue_tb import spq_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QDEPTH = 16;
  localparam int HOLD_CYCLES = 64;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  // One result word, field by field.
  typedef struct packed {
    logic             lowest_valid;
    logic [ID_W-1:0]  lowest_id;
    logic             next_valid;
    logic [ID_W-1:0]  next_id;
    logic             was_queued;
    logic [CNT_W-1:0] entry_count;
    logic [ERR_W-1:0] op_error;
  } result_t;

  // One directed word; typed marks a row whose result is written out by hand.
  typedef struct packed {
    logic [FUNC_W-1:0] op;
    logic [ID_W-1:0]   id;
    logic [31:0]       score;
    logic              typed;
    result_t           want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  spq_in_if  in_word ();
  spq_out_if out_word ();

  stable_priority_queue DUT (
    .clk      (clk),
    .rst      (rst),
    .in_word  (in_word),
    .out_word (out_word)
  );

  always #2 clk = ~clk;

  // Model of the queue contents, in order.
  logic [ID_W-1:0] ord_handle [QDEPTH];
  logic [31:0]     ord_key [QDEPTH];
  int              ord_count = 0;

  result_t pending_results [$];

  // Idle and stall control, set per phase.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int holds_asked = 0;
  int holds_done = 0;
  int hold_left = 0;

  // Tallies for the summary and the verdict.
  int mismatches = 0;
  int n_add = 0, n_readd = 0, n_remove = 0, n_query = 0, n_other = 0;
  int n_full = 0, n_empty = 0, n_absent = 0, stall_cycles = 0;

  // Directed words: reset state, key extremes, ties, filling up, re-add while full.
  stim_row_t dir_rows [25] = '{
    '{FUNC_QUERY,  4'd5,  32'h0000_0000, 1'b1, '{1'b0, 4'd0,  1'b0, 4'd0, 1'b0, 5'd0, ERR_ABSENT}},
    '{FUNC_REMOVE, 4'd0,  32'h0000_0000, 1'b1, '{1'b0, 4'd0,  1'b0, 4'd0, 1'b0, 5'd0, ERR_ABSENT}},
    '{FUNC_UNUSED, 4'd9,  32'hFFFF_FFFF, 1'b1, '{1'b0, 4'd0,  1'b0, 4'd0, 1'b0, 5'd0, ERR_NONE}},
    '{FUNC_ADD,    4'd15, 32'hFFFF_FFFF, 1'b1, '{1'b1, 4'd15, 1'b0, 4'd0, 1'b0, 5'd1, ERR_NONE}},
    '{FUNC_ADD,    4'd0,  32'h0000_0000, 1'b1, '{1'b1, 4'd0,  1'b0, 4'd0, 1'b0, 5'd2, ERR_NONE}},
    '{FUNC_ADD,    4'd7,  32'hFFFF_FFFF, 1'b0, '0},
    '{FUNC_QUERY,  4'd15, 32'h0000_0000, 1'b0, '0},
    '{FUNC_QUERY,  4'd7,  32'h0000_0000, 1'b0, '0},
    '{FUNC_ADD,    4'd15, 32'h0000_0000, 1'b0, '0},
    '{FUNC_ADD,    4'd1,  32'h8000_0000, 1'b0, '0},
    '{FUNC_ADD,    4'd2,  32'h0000_0001, 1'b0, '0},
    '{FUNC_ADD,    4'd3,  32'h0000_0000, 1'b0, '0},
    '{FUNC_ADD,    4'd4,  32'hFFFF_FFFE, 1'b0, '0},
    '{FUNC_ADD,    4'd5,  32'h5555_5555, 1'b0, '0},
    '{FUNC_ADD,    4'd6,  32'hAAAA_AAAA, 1'b0, '0},
    '{FUNC_ADD,    4'd8,  32'h0000_0007, 1'b0, '0},
    '{FUNC_ADD,    4'd9,  32'h0000_0007, 1'b0, '0},
    '{FUNC_ADD,    4'd10, 32'h0000_0007, 1'b0, '0},
    '{FUNC_ADD,    4'd11, 32'h0000_FFFF, 1'b0, '0},
    '{FUNC_ADD,    4'd12, 32'hFFFF_0000, 1'b0, '0},
    '{FUNC_ADD,    4'd13, 32'h1234_5678, 1'b0, '0},
    '{FUNC_ADD,    4'd14, 32'h8000_0000, 1'b0, '0},
    '{FUNC_ADD,    4'd3,  32'h0000_0005, 1'b0, '0},
    '{FUNC_REMOVE, 4'd9,  32'h0000_0000, 1'b0, '0},
    '{FUNC_QUERY,  4'd9,  32'h0000_0000, 1'b0, '0}
  };

  // Close the gap left by the entry at pos.
  function automatic void order_take_out(int pos);
    for (int i = pos; i + 1 < ord_count; i++) begin
      ord_handle[i] = ord_handle[i+1];
      ord_key[i]    = ord_key[i+1];
    end
    ord_count--;
  endfunction

  // Place an entry after every entry whose key is not greater.
  function automatic void order_insert(logic [ID_W-1:0] id, logic [31:0] key);
    int pos;
    pos = 0;
    while (pos < ord_count && ord_key[pos] <= key) pos++;
    for (int i = ord_count; i > pos; i--) begin
      ord_handle[i] = ord_handle[i-1];
      ord_key[i]    = ord_key[i-1];
    end
    ord_handle[pos] = id;
    ord_key[pos]    = key;
    ord_count++;
  endfunction

  // Apply one operation word to the model and return the result word it yields.
  function automatic result_t order_apply(logic [FUNC_W-1:0] op, logic [ID_W-1:0] id,
                                          logic [31:0] key);
    result_t r;
    int pos;
    r = '0;
    pos = -1;
    for (int i = 0; i < ord_count; i++) begin
      if (ord_handle[i] == id) pos = i;
    end
    r.was_queued = (pos >= 0);
    case (op)
      FUNC_ADD: begin
        if (pos >= 0) begin
          order_take_out(pos);
          order_insert(id, key);
        end else if (ord_count >= QDEPTH) begin
          r.op_error = ERR_FULL;
        end else begin
          order_insert(id, key);
        end
      end
      FUNC_REMOVE: begin
        if (pos >= 0) order_take_out(pos);
        else r.op_error = ERR_ABSENT;
      end
      FUNC_QUERY: begin
        if (pos < 0) begin
          r.op_error = ERR_ABSENT;
        end else if (pos + 1 < ord_count) begin
          r.next_valid = 1'b1;
          r.next_id    = ord_handle[pos+1];
        end
      end
      default: ;
    endcase
    r.lowest_valid = (ord_count > 0);
    r.lowest_id    = (ord_count > 0) ? ord_handle[0] : '0;
    r.entry_count  = CNT_W'(ord_count);
    return r;
  endfunction

  // Offer one word, wait for it to be taken, then record what it should produce.
  task automatic send_word(logic [FUNC_W-1:0] op, logic [ID_W-1:0] id, logic [31:0] score,
                           logic typed, result_t want);
    result_t r;
    if ($urandom_range(99) < send_idle_pct) begin
      in_word.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_word.valid    <= 1'b1;
    in_word.func     <= op;
    in_word.entry_id <= id;
    in_word.score    <= score;
    do @(posedge clk); while (!in_word.ready);
    r = order_apply(op, id, score);
    pending_results.push_back(typed ? want : r);
    case (op)
      FUNC_ADD: begin
        n_add++;
        if (r.was_queued) n_readd++;
      end
      FUNC_REMOVE: n_remove++;
      FUNC_QUERY:  n_query++;
      default:     n_other++;
    endcase
    if (r.entry_count == CNT_W'(QDEPTH)) n_full++;
    if (r.entry_count == '0) n_empty++;
    if (r.op_error == ERR_ABSENT) n_absent++;
  endtask

  // Random words; add_pct steers the queue toward full or toward empty.
  task automatic send_random(int count, int add_pct);
    logic [FUNC_W-1:0] op;
    logic [ID_W-1:0]   id;
    logic [31:0]       score;
    int                sel;
    repeat (count) begin
      sel = $urandom_range(99);
      if (sel < 4) op = FUNC_UNUSED;
      else if (sel < add_pct) op = FUNC_ADD;
      else if (sel < add_pct + (100 - add_pct) / 2) op = FUNC_REMOVE;
      else op = FUNC_QUERY;
      // Mostly name a queued handle for remove and query so they find something.
      if (op != FUNC_ADD && ord_count > 0 && $urandom_range(99) < 60)
        id = ord_handle[$urandom_range(ord_count - 1)];
      else
        id = ID_W'($urandom_range(15));
      case ($urandom_range(3))
        0: score = 32'($urandom_range(3));
        1: score = $urandom;
        2: score = 32'hFFFF_FFFC | 32'($urandom_range(3));
        default: score = (ord_count > 0) ? ord_key[$urandom_range(ord_count - 1)] : '0;
      endcase
      send_word(op, id, score, 1'b0, '0);
    end
  endtask

  task automatic flag_field(string name, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= 40)
      $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
  endtask

  // Receiver: random stalls, plus a long hold-off when one is asked for.
  always @(posedge clk) begin
    if (hold_left == 0 && holds_done < holds_asked) begin
      hold_left = HOLD_CYCLES;
      holds_done++;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_word.ready <= 1'b0;
    end else begin
      out_word.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Count cycles in which the block holds off a waiting word.
  always @(posedge clk) begin
    if (!rst && in_word.valid && !in_word.ready) stall_cycles++;
  end

  // Compare each result word with the oldest expectation.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && out_word.valid && out_word.ready) begin
      got.lowest_valid = out_word.lowest_valid;
      got.lowest_id    = out_word.lowest_id;
      got.next_valid   = out_word.next_valid;
      got.next_id      = out_word.next_id;
      got.was_queued   = out_word.was_queued;
      got.entry_count  = out_word.entry_count;
      got.op_error     = out_word.op_error;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 40)
          $display("%0t ns: result word with nothing expected, expected none, got %p",
                   $time, got);
      end else begin
        want = pending_results.pop_front();
        if (got.lowest_valid !== want.lowest_valid)
          flag_field("lowest_valid", want.lowest_valid, got.lowest_valid);
        if (got.lowest_id !== want.lowest_id)
          flag_field("lowest_id", want.lowest_id, got.lowest_id);
        if (got.next_valid !== want.next_valid)
          flag_field("next_valid", want.next_valid, got.next_valid);
        if (got.next_id !== want.next_id)
          flag_field("next_id", want.next_id, got.next_id);
        if (got.was_queued !== want.was_queued)
          flag_field("was_queued", want.was_queued, got.was_queued);
        if (got.entry_count !== want.entry_count)
          flag_field("entry_count", want.entry_count, got.entry_count);
        if (got.op_error !== want.op_error)
          flag_field("op_error", want.op_error, got.op_error);
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    in_word.valid    = 1'b0;
    in_word.func     = FUNC_ADD;
    in_word.entry_id = '0;
    in_word.score    = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i])
      send_word(dir_rows[i].op, dir_rows[i].id, dir_rows[i].score,
                dir_rows[i].typed, dir_rows[i].want);

    // Random phases with different idle and stall mixes and add/remove balance.
    send_random(250, 45);
    send_idle_pct = 58;
    send_random(250, 80);
    send_idle_pct = 0;
    recv_stall_pct = 58;
    send_random(250, 15);
    send_idle_pct = 27;
    recv_stall_pct = 27;
    send_random(250, 45);

    // Long receiver hold-off while words keep coming, to back up the input.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    holds_asked++;
    send_random(150, 50);
    send_random(100, 20);
    in_word.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Covered %0d adds (%0d re-adds), %0d removes, %0d queries, %0d unused codes.",
             n_add, n_readd, n_remove, n_query, n_other);
    $display("Queue full after %0d words, empty after %0d, %0d absent errors, %0d input stalls.",
             n_full, n_empty, n_absent, stall_cycles);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2000000;
    $display("Timed out with %0d results still expected.", pending_results.size());
    $display("status: fail");
    $finish;
  end

endmodule
